>>> src/flood_route_bundle_table_defines.svh
// Assertion macros for the flood-routing bundle table.
// Used by the port checker; depends on nothing.
`ifndef FLOOD_ROUTE_BUNDLE_TABLE_DEFINES_SVH
`define FLOOD_ROUTE_BUNDLE_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FRBT_ASSERT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("frbt: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FRBT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("frbt: assertion failed");

`endif

>>> src/frbt_pkg.sv
// Shared types and constants of the flood-routing bundle table.
// Used by the table cell, the top level and the port checker; no dependencies.
package frbt_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF  = 10;
  localparam int unsigned NEIGHBOR_SLOTS_DEF = 1;

  localparam int unsigned BUNDLE_W = 16;
  localparam int unsigned SOURCE_W = 32;
  localparam int unsigned ADDR_W   = 16;

  typedef enum logic [1:0] {
    FUNC_NEIGHBOR = 2'd0,
    FUNC_INSERT   = 2'd1,
    FUNC_DELETE   = 2'd2,
    FUNC_TX_DONE  = 2'd3
  } func_e;

  typedef enum logic {
    KIND_OFFER  = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    STATUS_DONE      = 3'd0,
    STATUS_DUPLICATE = 3'd1,
    STATUS_FULL      = 3'd2,
    STATUS_NOT_FOUND = 3'd3,
    STATUS_IGNORED   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_SHIFT  = 2'd1,
    CELL_LOAD   = 2'd2,
    CELL_RECORD = 2'd3
  } cell_op_e;

  // Command to one cell: its operation plus the broadcast request fields.
  typedef struct packed {
    cell_op_e            op;
    logic [BUNDLE_W-1:0] bundle;
    logic [SOURCE_W-1:0] source;
    logic [ADDR_W-1:0]   nbr;
  } cell_ctrl_t;

  // Status one cell reports back against the broadcast request.
  typedef struct packed {
    logic valid;
    logic match;
    logic offer;
    logic at_limit;
  } cell_stat_t;

endpackage

>>> src/frbt_cell.sv
// One entry of the flood-routing bundle table.
// Depends on frbt_pkg; loads, records, or takes its neighbor's contents.
module frbt_cell #(
  parameter int unsigned NEIGHBOR_SLOTS = frbt_pkg::NEIGHBOR_SLOTS_DEF,
  localparam int unsigned CNT_W = $clog2(NEIGHBOR_SLOTS + 1)
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  frbt_pkg::cell_ctrl_t                            ctrl_i,
  input  logic                                            nxt_valid_i,
  input  logic [frbt_pkg::BUNDLE_W-1:0]                   nxt_bundle_i,
  input  logic [frbt_pkg::SOURCE_W-1:0]                   nxt_source_i,
  input  logic [NEIGHBOR_SLOTS-1:0][frbt_pkg::ADDR_W-1:0] nxt_sent_i,
  input  logic [CNT_W-1:0]                                nxt_count_i,
  output logic                                            valid_o,
  output logic [frbt_pkg::BUNDLE_W-1:0]                   bundle_o,
  output logic [frbt_pkg::SOURCE_W-1:0]                   source_o,
  output logic [NEIGHBOR_SLOTS-1:0][frbt_pkg::ADDR_W-1:0] sent_o,
  output logic [CNT_W-1:0]                                count_o,
  output frbt_pkg::cell_stat_t                            stat_o
);
  import frbt_pkg::*;

  logic                                  valid_q, valid_d;
  logic [BUNDLE_W-1:0]                   bundle_q, bundle_d;
  logic [SOURCE_W-1:0]                   source_q, source_d;
  logic [NEIGHBOR_SLOTS-1:0][ADDR_W-1:0] sent_q, sent_d;
  logic [CNT_W-1:0]                      count_q, count_d;
  logic                                  sourced;
  logic                                  seen;

  always_comb begin
    valid_d  = valid_q;
    bundle_d = bundle_q;
    source_d = source_q;
    sent_d   = sent_q;
    count_d  = count_q;
    case (ctrl_i.op)
      CELL_SHIFT: begin
        valid_d  = nxt_valid_i;
        bundle_d = nxt_bundle_i;
        source_d = nxt_source_i;
        sent_d   = nxt_sent_i;
        count_d  = nxt_count_i;
      end
      CELL_LOAD: begin
        valid_d  = 1'b1;
        bundle_d = ctrl_i.bundle;
        source_d = ctrl_i.source;
        sent_d   = '0;
        count_d  = '0;
      end
      CELL_RECORD: begin
        // Write the next free slot, then advance the count.
        for (int s = 0; s < NEIGHBOR_SLOTS; s++) begin
          if (CNT_W'(s) == count_q) begin
            sent_d[s] = ctrl_i.nbr;
          end
        end
        count_d = count_q + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sourced = (source_q == {{(SOURCE_W - 8){1'b0}}, ctrl_i.nbr[7:0]});
    seen    = 1'b0;
    for (int s = 0; s < NEIGHBOR_SLOTS; s++) begin
      if (sent_q[s] == ctrl_i.nbr) begin
        seen = 1'b1;
      end
    end
    stat_o.valid    = valid_q;
    stat_o.match    = valid_q && (bundle_q == ctrl_i.bundle);
    stat_o.offer    = valid_q && !sourced && !seen;
    stat_o.at_limit = (count_q == CNT_W'(NEIGHBOR_SLOTS));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sent_q  <= '0;
      count_q <= '0;
    end else begin
      valid_q <= valid_d;
      sent_q  <= sent_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bundle_q <= bundle_d;
    source_q <= source_d;
  end

  assign valid_o  = valid_q;
  assign bundle_o = bundle_q;
  assign source_o = source_q;
  assign sent_o   = sent_q;
  assign count_o  = count_q;

endmodule

>>> src/flood_route_bundle_table.sv
// Top level of the flood-routing bundle table: a chain of frbt_cell entries
// and the request sequencer. Depends on frbt_pkg and frbt_cell.
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+-------------------------------------
//  request   | start, busy (start && !busy) | func_i, bundle_num_i, source_node_i,
//            |                              | neighbor_addr_i, tx_ok_i
//  result    | res_strobe_o (one cycle)     | kind_o, out_bundle_o, out_neighbor_o,
//            |                              | status_o, discard_request_o, last_o
//
// Insert, delete and transmit done hold busy in their execute state; the status
// result shows in the cycle after. A new neighbor holds busy through the scan and
// flush: the chain rotates one entry per cycle past the head cell, so the table
// depth sets the scan length. Each offer waits until the next one is found or the
// scan ends, so that the final one can carry last. Reset clears valid bits, sent
// slots and counts at once; the receiver cannot stall, each result lasts a cycle.
module flood_route_bundle_table #(
  parameter int unsigned TABLE_ENTRIES  = frbt_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned NEIGHBOR_SLOTS = frbt_pkg::NEIGHBOR_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [15:0] bundle_num_i,
  input  logic [31:0] source_node_i,
  input  logic [15:0] neighbor_addr_i,
  input  logic        tx_ok_i,
  output logic        res_strobe_o,
  output logic        kind_o,
  output logic [15:0] out_bundle_o,
  output logic [15:0] out_neighbor_o,
  output logic [2:0]  status_o,
  output logic        discard_request_o,
  output logic        last_o
);
  import frbt_pkg::*;

  localparam int unsigned CNT_W = $clog2(NEIGHBOR_SLOTS + 1);
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  state_e              state_q;
  func_e               req_func_q;
  logic [BUNDLE_W-1:0] req_bundle_q;
  logic [SOURCE_W-1:0] req_source_q;
  logic [ADDR_W-1:0]   req_nbr_q;
  logic                req_ok_q;
  logic [IDX_W-1:0]    scan_q;
  logic                pend_q;
  logic [BUNDLE_W-1:0] pend_bundle_q;

  logic                res_strobe_q;
  kind_e               kind_q;
  logic [BUNDLE_W-1:0] out_bundle_q;
  logic [ADDR_W-1:0]   out_nbr_q;
  status_e             status_q;
  logic                disc_q;
  logic                last_q;

  // Cell chain wiring.
  cell_ctrl_t                            cell_ctrl  [TABLE_ENTRIES];
  cell_stat_t                            cell_stat  [TABLE_ENTRIES];
  logic                                  cell_valid [TABLE_ENTRIES];
  logic [BUNDLE_W-1:0]                   cell_bundle[TABLE_ENTRIES];
  logic [SOURCE_W-1:0]                   cell_source[TABLE_ENTRIES];
  logic [NEIGHBOR_SLOTS-1:0][ADDR_W-1:0] cell_sent  [TABLE_ENTRIES];
  logic [CNT_W-1:0]                      cell_count [TABLE_ENTRIES];

  // What the last cell takes in on a shift: the head during a scan
  // (rotation), an empty entry on removal.
  logic                                  wrap_valid;
  logic [BUNDLE_W-1:0]                   wrap_bundle;
  logic [SOURCE_W-1:0]                   wrap_source;
  logic [NEIGHBOR_SLOTS-1:0][ADDR_W-1:0] wrap_sent;
  logic [CNT_W-1:0]                      wrap_count;

  cell_op_e exec_op[TABLE_ENTRIES];
  status_e  exec_status;
  logic     exec_disc;
  logic     any_match;
  logic     limit_hit;
  logic     full;
  logic     hit;
  logic     after_match[TABLE_ENTRIES];
  logic     insert_here[TABLE_ENTRIES];

  assign busy = (state_q != ST_IDLE);

  always_comb begin
    if (state_q == ST_SCAN) begin
      wrap_valid  = cell_valid[0];
      wrap_bundle = cell_bundle[0];
      wrap_source = cell_source[0];
      wrap_sent   = cell_sent[0];
      wrap_count  = cell_count[0];
    end else begin
      wrap_valid  = 1'b0;
      wrap_bundle = cell_bundle[0];
      wrap_source = cell_source[0];
      wrap_sent   = '0;
      wrap_count  = '0;
    end
  end

  // Match, removal range and insertion point, from the cells' own flags.
  always_comb begin
    any_match = 1'b0;
    limit_hit = 1'b0;
    hit       = 1'b0;
    full      = cell_valid[TABLE_ENTRIES-1];
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      any_match      = any_match | cell_stat[i].match;
      limit_hit      = limit_hit | (cell_stat[i].match & cell_stat[i].at_limit);
      hit            = hit | cell_stat[i].match;
      after_match[i] = hit;
      insert_here[i] = !cell_valid[i] && ((i == 0) || cell_valid[(i == 0) ? 0 : i - 1]);
    end
  end

  always_comb begin
    exec_status = STATUS_DONE;
    exec_disc   = 1'b0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      exec_op[i] = CELL_HOLD;
    end
    case (req_func_q)
      FUNC_INSERT: begin
        if (any_match) begin
          exec_status = STATUS_DUPLICATE;
        end else if (full) begin
          exec_status = STATUS_FULL;
        end else begin
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (insert_here[i]) exec_op[i] = CELL_LOAD;
          end
        end
      end
      FUNC_DELETE: begin
        if (!any_match) begin
          exec_status = STATUS_NOT_FOUND;
        end else begin
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (after_match[i]) exec_op[i] = CELL_SHIFT;
          end
        end
      end
      FUNC_TX_DONE: begin
        if (!req_ok_q) begin
          exec_status = STATUS_IGNORED;
        end else if (!any_match) begin
          exec_status = STATUS_NOT_FOUND;
        end else if (limit_hit) begin
          // Sent to every slot already: drop the entry and ask for discard.
          exec_disc = 1'b1;
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (after_match[i]) exec_op[i] = CELL_SHIFT;
          end
        end else begin
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (cell_stat[i].match) exec_op[i] = CELL_RECORD;
          end
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    always_comb begin
      cell_ctrl[g].bundle = req_bundle_q;
      cell_ctrl[g].source = req_source_q;
      cell_ctrl[g].nbr    = req_nbr_q;
      case (state_q)
        ST_EXEC: cell_ctrl[g].op = exec_op[g];
        ST_SCAN: cell_ctrl[g].op = CELL_SHIFT;
        default: cell_ctrl[g].op = CELL_HOLD;
      endcase
    end

    if (g == TABLE_ENTRIES - 1) begin : g_tail
      frbt_cell #(
        .NEIGHBOR_SLOTS(NEIGHBOR_SLOTS)
      ) u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctrl_i      (cell_ctrl[g]),
        .nxt_valid_i (wrap_valid),
        .nxt_bundle_i(wrap_bundle),
        .nxt_source_i(wrap_source),
        .nxt_sent_i  (wrap_sent),
        .nxt_count_i (wrap_count),
        .valid_o     (cell_valid[g]),
        .bundle_o    (cell_bundle[g]),
        .source_o    (cell_source[g]),
        .sent_o      (cell_sent[g]),
        .count_o     (cell_count[g]),
        .stat_o      (cell_stat[g])
      );
    end else begin : g_body
      frbt_cell #(
        .NEIGHBOR_SLOTS(NEIGHBOR_SLOTS)
      ) u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctrl_i      (cell_ctrl[g]),
        .nxt_valid_i (cell_valid[g+1]),
        .nxt_bundle_i(cell_bundle[g+1]),
        .nxt_source_i(cell_source[g+1]),
        .nxt_sent_i  (cell_sent[g+1]),
        .nxt_count_i (cell_count[g+1]),
        .valid_o     (cell_valid[g]),
        .bundle_o    (cell_bundle[g]),
        .source_o    (cell_source[g]),
        .sent_o      (cell_sent[g]),
        .count_o     (cell_count[g]),
        .stat_o      (cell_stat[g])
      );
    end
  end

  // Sequencer and registered results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      req_func_q    <= FUNC_NEIGHBOR;
      req_bundle_q  <= '0;
      req_source_q  <= '0;
      req_nbr_q     <= '0;
      req_ok_q      <= 1'b0;
      scan_q        <= '0;
      pend_q        <= 1'b0;
      pend_bundle_q <= '0;
      res_strobe_q  <= 1'b0;
      kind_q        <= KIND_OFFER;
      out_bundle_q  <= '0;
      out_nbr_q     <= '0;
      status_q      <= STATUS_DONE;
      disc_q        <= 1'b0;
      last_q        <= 1'b0;
    end else begin
      res_strobe_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            req_func_q   <= func_e'(func_i);
            req_bundle_q <= bundle_num_i;
            req_source_q <= source_node_i;
            req_nbr_q    <= neighbor_addr_i;
            req_ok_q     <= tx_ok_i;
            scan_q       <= '0;
            pend_q       <= 1'b0;
            state_q      <= (func_e'(func_i) == FUNC_NEIGHBOR) ? ST_SCAN : ST_EXEC;
          end
        end
        ST_EXEC: begin
          res_strobe_q <= 1'b1;
          kind_q       <= KIND_STATUS;
          out_bundle_q <= req_bundle_q;
          out_nbr_q    <= (req_func_q == FUNC_TX_DONE) ? req_nbr_q : '0;
          status_q     <= exec_status;
          disc_q       <= exec_disc;
          last_q       <= 1'b1;
          state_q      <= ST_IDLE;
        end
        ST_SCAN: begin
          // Hold the newest offer back until the next one shows it is not last.
          if (cell_stat[0].offer) begin
            if (pend_q) begin
              res_strobe_q <= 1'b1;
              kind_q       <= KIND_OFFER;
              out_bundle_q <= pend_bundle_q;
              out_nbr_q    <= req_nbr_q;
              status_q     <= STATUS_DONE;
              disc_q       <= 1'b0;
              last_q       <= 1'b0;
            end
            pend_q        <= 1'b1;
            pend_bundle_q <= cell_bundle[0];
          end
          if (scan_q == IDX_W'(TABLE_ENTRIES - 1)) begin
            state_q <= ST_FLUSH;
          end else begin
            scan_q <= scan_q + IDX_W'(1);
          end
        end
        ST_FLUSH: begin
          if (pend_q) begin
            res_strobe_q <= 1'b1;
            kind_q       <= KIND_OFFER;
            out_bundle_q <= pend_bundle_q;
            out_nbr_q    <= req_nbr_q;
            status_q     <= STATUS_DONE;
            disc_q       <= 1'b0;
            last_q       <= 1'b1;
          end
          pend_q  <= 1'b0;
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_strobe_o      = res_strobe_q;
  assign kind_o            = kind_q;
  assign out_bundle_o      = out_bundle_q;
  assign out_neighbor_o    = out_nbr_q;
  assign status_o          = status_q;
  assign discard_request_o = disc_q;
  assign last_o            = last_q;

endmodule

>>> src/frbt_checker.sv
// Port-level checker for the flood-routing bundle table, bound to the top.
// Depends on frbt_pkg and flood_route_bundle_table_defines.svh.
`include "flood_route_bundle_table_defines.svh"

module frbt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       res_strobe_o,
  input logic       kind_o,
  input logic [2:0] status_o,
  input logic       discard_request_o,
  input logic       last_o
);
  import frbt_pkg::*;

  logic offer_strobe;
  logic status_strobe;
  logic offer_clean;

  assign offer_strobe  = res_strobe_o && (kind_o == KIND_OFFER);
  assign status_strobe = res_strobe_o && (kind_o == KIND_STATUS);
  assign offer_clean   = (status_o == STATUS_DONE) && !discard_request_o;

  // An accepted request always makes the block busy.
  `FRBT_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)

  // Status results are single and therefore always last.
  `FRBT_ASSERT(a_status_last, clk_i, rst_ni, status_strobe, last_o)

  // Offers carry no status and never request discard.
  `FRBT_ASSERT(a_offer_clean, clk_i, rst_ni, offer_strobe, offer_clean)

  // An offer that is not last means the scan is still running.
  `FRBT_ASSERT(a_offer_more, clk_i, rst_ni, offer_strobe && !last_o, busy)

endmodule

bind flood_route_bundle_table frbt_checker u_frbt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .res_strobe_o     (res_strobe_o),
  .kind_o           (kind_o),
  .status_o         (status_o),
  .discard_request_o(discard_request_o),
  .last_o           (last_o)
);
